// ----- rtl/mts_pkg.sv -----
// Shared types and codes for the melody tone sequencer.
// No dependencies; imported by mts_arith and melody_tone_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned DIV_W  = 8;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STEPS  = 16;
  localparam int unsigned STEP_W = $clog2(STEPS);

  // item command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WHOLE_NOTE = 2'd0;
  localparam logic [1:0] CFG_PAUSE      = 2'd1;
  localparam logic [1:0] CFG_LENGTH     = 2'd2;

  // shared unit operations
  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] result;
  } arith_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/melody_tone_sequencer.sv -----
// Melody tone sequencer top level: note table, sequencer and configuration.
// Depends on mts_pkg and mts_arith.
//
// Usage: items enter on in_* (valid/ready). Load items write a note table entry,
// start items rewind the melody, tick items advance time by one millisecond.
// Every item yields exactly one result on out_* (valid/ready) carrying the tone
// for that tick and the position and over flag after it.
// Path from acceptance to result valid: loads, plain ticks and unused codes go
// straight to the output register, a tick that sounds first reads the table, a
// tick that starts a pause runs a 16-step multiply in the shared unit, and a
// start or a note change reads the table, then runs a 16-step divide.
// in_ready is high only while no item is in work, so the next item can be
// taken in the cycle after the result is registered, and no new item is
// taken before the last one is through.
// A result waiting in the output register does not block the next item; only
// a second result waits (the sequencer holds) until out_ready takes the first.
// Reset (synchronous, active low) restores register defaults, rewinds to
// position 0 with the melody over; the note table is not cleared and must be
// loaded before it is played. Configuration writes on cfg_* are taken at once.
`timescale 1ns / 1ps
`default_nettype none

module melody_tone_sequencer import mts_pkg::*; #(
  parameter int unsigned MAX_NOTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_command,
  input  wire logic [5:0]        in_note_slot,
  input  wire logic [15:0]       in_note_freq,
  input  wire logic [DIV_W-1:0]  in_note_divisor,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_tone_on,
  output logic [15:0]            out_tone_freq,
  output logic [POS_W-1:0]       out_note_position,
  output logic                   out_melody_over
);

  localparam int unsigned AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_ARITH = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]        state_r;
  logic [TIME_W-1:0] whole_note_r;
  logic [TIME_W-1:0] pause_r;
  logic [POS_W-1:0]  length_r;

  logic [POS_W-1:0]  position_r;
  logic              in_note_r;
  logic [TIME_W-1:0] note_time_r;
  logic [TIME_W-1:0] time_left_r;
  logic              finished_r;
  logic              rd_freq_r;
  logic              calc_div_r;
  logic              tone_on_r;
  logic [15:0]       tone_freq_r;

  logic              out_valid_r;
  logic              out_tone_on_r;
  logic [15:0]       out_tone_freq_r;
  logic [POS_W-1:0]  out_position_r;
  logic              out_over_r;

  logic [TIME_W+DIV_W-1:0] mem [MAX_NOTES];
  logic [TIME_W+DIV_W-1:0] mem_rd_r;
  logic [AW-1:0]           addr_r;
  logic                    mem_we;

  logic [POS_W-1:0]  eff_len;
  logic [POS_W-1:0]  next_pos;
  logic              accept;
  logic              out_free;

  arith_req_t        a_req;
  arith_rsp_t        a_rsp;
  logic [TIME_W-1:0] a_opa, a_opb;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign eff_len  = (32'(length_r) > 32'(MAX_NOTES)) ? POS_W'(MAX_NOTES) : length_r;
  assign next_pos = position_r + 1'b1;
  assign mem_we   = accept && (in_command == CMD_LOAD)
                    && (32'(in_note_slot) < 32'(MAX_NOTES));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_note_slot)] <= {in_note_freq, in_note_divisor};
    end
    mem_rd_r <= mem[addr_r];
  end

  always_comb begin
    a_req.start = 1'b0;
    a_req.op    = OP_DIV;
    a_opa       = whole_note_r;
    a_opb       = {{(TIME_W-DIV_W){1'b0}}, mem_rd_r[DIV_W-1:0]};
    if (state_r == ST_FETCH && !rd_freq_r) begin
      a_req.start = 1'b1;
    end else if (state_r == ST_MUL) begin
      a_req.start = 1'b1;
      a_req.op    = OP_MUL;
      a_opa       = note_time_r;
      a_opb       = pause_r;
    end
  end

  mts_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (a_req),
    .opa   (a_opa),
    .opb   (a_opb),
    .rsp   (a_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_note_r <= 16'd1000;
      pause_r      <= 16'd333;
      length_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHOLE_NOTE: whole_note_r <= cfg_wdata;
        CFG_PAUSE:      pause_r      <= cfg_wdata;
        CFG_LENGTH:     length_r     <= cfg_wdata[POS_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      position_r  <= '0;
      in_note_r   <= 1'b1;
      note_time_r <= '0;
      time_left_r <= '0;
      finished_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            tone_on_r   <= 1'b0;
            tone_freq_r <= '0;
            state_r     <= ST_OUT;
            if (in_command == CMD_START) begin
              position_r <= '0;
              in_note_r  <= 1'b1;
              finished_r <= 1'b0;
              addr_r     <= '0;
              rd_freq_r  <= 1'b0;
              state_r    <= ST_RD;
            end else if (in_command == CMD_TICK) begin
              if (position_r >= eff_len) begin
                finished_r <= 1'b1;
              end else if (in_note_r) begin
                if (time_left_r == '0) begin
                  in_note_r <= 1'b0;
                  state_r   <= ST_MUL;
                end else begin
                  tone_on_r   <= 1'b1;
                  time_left_r <= time_left_r - 1'b1;
                  addr_r      <= AW'(position_r);
                  rd_freq_r   <= 1'b1;
                  state_r     <= ST_RD;
                end
              end else if (time_left_r == '0) begin
                in_note_r  <= 1'b1;
                position_r <= next_pos;
                if (next_pos < eff_len) begin
                  addr_r    <= AW'(next_pos);
                  rd_freq_r <= 1'b0;
                  state_r   <= ST_RD;
                end
              end else begin
                time_left_r <= time_left_r - 1'b1;
              end
            end
          end
        end
        ST_RD: state_r <= ST_FETCH;
        ST_FETCH: begin
          if (rd_freq_r) begin
            tone_freq_r <= mem_rd_r[TIME_W+DIV_W-1:DIV_W];
            state_r     <= ST_OUT;
          end else begin
            calc_div_r <= 1'b1;
            state_r    <= ST_ARITH;
          end
        end
        ST_MUL: begin
          calc_div_r <= 1'b0;
          state_r    <= ST_ARITH;
        end
        ST_ARITH: begin
          if (a_rsp.done) begin
            time_left_r <= a_rsp.result;
            if (calc_div_r) begin
              note_time_r <= a_rsp.result;
            end
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_tone_on_r   <= tone_on_r;
            out_tone_freq_r <= tone_freq_r;
            out_position_r  <= position_r;
            out_over_r      <= finished_r;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tone_on       = out_tone_on_r;
  assign out_tone_freq     = out_tone_freq_r;
  assign out_note_position = out_position_r;
  assign out_melody_over   = out_over_r;

  // the shared unit only finishes while the sequencer waits on it
  a_done_in_arith: assert property (@(posedge clk) disable iff (!rst_n)
    a_rsp.done |-> state_r == ST_ARITH)
    else $error("shared unit finished outside its wait state");

  // an accepted item keeps the sequencer busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("item accepted while another is in work");

  // a silent result reports no frequency
  a_silent_no_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tone_on) |-> out_tone_freq == '0)
    else $error("silent result carries a frequency");

endmodule

`default_nettype wire

// ----- rtl/mts_arith.sv -----
// Shared iterative unit: restoring divide or shift-add multiply, one bit per cycle.
// Depends on mts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mts_arith import mts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire arith_req_t        req,
  input  wire logic [TIME_W-1:0] opa,
  input  wire logic [TIME_W-1:0] opb,
  output arith_rsp_t             rsp
);

  logic [TIME_W:0]   hi_r, hi_nxt;
  logic [TIME_W-1:0] lo_r, lo_nxt;
  logic [TIME_W-1:0] b_r;
  logic              op_r;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;

  logic [TIME_W:0]   add_a, add_b;
  logic              add_cin;
  logic [TIME_W+1:0] add_sum;
  logic [TIME_W:0]   shifted;

  // the one adder, used as subtractor for the divide
  always_comb begin
    shifted = {hi_r[TIME_W-1:0], lo_r[TIME_W-1]};
    if (op_r == OP_DIV) begin
      add_a   = shifted;
      add_b   = ~{1'b0, b_r};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, hi_r[TIME_W-1:0]};
      add_b   = lo_r[0] ? {1'b0, b_r} : '0;
      add_cin = 1'b0;
    end
    add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(TIME_W+1){1'b0}}, add_cin};
  end

  always_comb begin
    if (op_r == OP_DIV) begin
      // carry out means no borrow: quotient bit is one (all ones for a zero divisor)
      if (add_sum[TIME_W+1]) begin
        hi_nxt = add_sum[TIME_W:0];
        lo_nxt = {lo_r[TIME_W-2:0], 1'b1};
      end else begin
        hi_nxt = shifted;
        lo_nxt = {lo_r[TIME_W-2:0], 1'b0};
      end
    end else begin
      hi_nxt = {1'b0, add_sum[TIME_W:1]};
      lo_nxt = {add_sum[0], lo_r[TIME_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hi_r <= '0;
      lo_r <= opa;
      b_r  <= opb;
      op_r <= req.op;
    end else if (run_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  // quotient for the divide; product >> 8, saturated to 16 bits, for the multiply
  always_comb begin
    rsp.done = done_r;
    if (op_r == OP_DIV) begin
      rsp.result = lo_r;
    end else if (hi_r[TIME_W-1:8] != '0) begin
      rsp.result = '1;
    end else begin
      rsp.result = {hi_r[7:0], lo_r[TIME_W-1:8]};
    end
  end

endmodule

`default_nettype wire
